>>> sv/fws_pkg.sv
package fws_pkg;

   localparam int THRESH_W = 48;
   localparam int COUNT_W  = 32;
   localparam int PROB_W   = 32;
   localparam int DRAW_W   = 16;
   localparam int LCG_W    = 64;
   localparam int ROOT_W   = 32;
   localparam int SQRT_W   = 64;
   localparam int REM_W    = 33;
   localparam int UNIT_W   = 35;
   localparam int STEP_W   = 6;

   localparam int LCG_MUL_W = 35;
   localparam logic [LCG_MUL_W-1:0] LCG_MUL = 35'd25214903917;
   localparam logic [LCG_W-1:0]     LCG_ADD = 64'd11;
   localparam logic [LCG_W-1:0]     LCG_SEED = 64'd1;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 48'd65536;
   localparam logic [PROB_W-1:0]   PROB_MAX     = '1;

   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(THRESH_W - 1);
   localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);
   localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(LCG_MUL_W - 1);

   // result of the shared divide / square-root sequencer
   typedef struct packed {
      logic                done;
      logic [THRESH_W-1:0] ratio;
      logic [ROOT_W-1:0]   root;
   } arith_res_type;

endpackage

>>> sv/fws_lcg.sv
module fws_lcg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     done,
   output logic [fws_pkg::LCG_W-1:0] state
);
   import fws_pkg::*;

   logic [LCG_W-1:0]  state_ff, state_in;
   logic [LCG_W-1:0]  acc_ff, acc_in;
   logic [LCG_W-1:0]  mcand_ff, mcand_in;
   logic [STEP_W-1:0] bit_ff, bit_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [LCG_W-1:0]  acc_sum;

   // shift-and-add over the bits of the constant multiplier
   assign acc_sum = acc_ff + (LCG_MUL[bit_ff] ? mcand_ff : '0);

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      bit_in   = bit_ff;
      run_in   = run_ff;
      done_in  = done_ff;
      if (start) begin
         acc_in   = LCG_ADD;
         mcand_in = state_ff;
         bit_in   = '0;
         run_in   = 1'b1;
         done_in  = 1'b0;
      end else if (run_ff) begin
         acc_in   = acc_sum;
         mcand_in = {mcand_ff[LCG_W-2:0], 1'b0};
         bit_in   = bit_ff + 1'b1;
         if (bit_ff == MUL_LAST) begin
            state_in = acc_sum;
            run_in   = 1'b0;
            done_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LCG_SEED;
         bit_ff   <= '0;
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         bit_ff   <= bit_in;
         run_ff   <= run_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
   end

   assign done  = done_ff;
   assign state = state_ff;

endmodule

>>> sv/fws_arith.sv
module fws_arith (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fws_pkg::THRESH_W-1:0] threshold,
   input  logic [fws_pkg::COUNT_W-1:0]  count,
   output fws_pkg::arith_res_type       res
);
   import fws_pkg::*;

   localparam logic [1:0] A_IDLE = 2'd0;
   localparam logic [1:0] A_DIV  = 2'd1;
   localparam logic [1:0] A_SQRT = 2'd2;
   localparam logic [1:0] A_DONE = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [SQRT_W-1:0]   work_ff, work_in;
   logic [THRESH_W-1:0] ratio_ff, ratio_in;
   logic [ROOT_W-1:0]   root_ff, root_in;

   logic [UNIT_W-1:0]   unit_a, unit_b;
   logic [UNIT_W:0]     unit_diff;
   logic                unit_ge;

   // the one shared subtract-and-compare unit
   always_comb begin
      if (state_ff == A_SQRT) begin
         unit_a = {rem_ff, work_ff[SQRT_W-1 -: 2]};
         unit_b = {1'b0, root_ff, 2'b01};
      end else begin
         unit_a = {2'b00, rem_ff[COUNT_W-1:0], work_ff[THRESH_W-1]};
         unit_b = {3'b000, count_ff};
      end
   end

   assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
   assign unit_ge   = !unit_diff[UNIT_W];

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      work_in  = work_ff;
      ratio_in = ratio_ff;
      root_in  = root_ff;
      if (start) begin
         state_in = A_DIV;
         step_in  = '0;
         count_in = count;
         rem_in   = '0;
         work_in  = {(SQRT_W-THRESH_W)'(0), threshold};
      end else begin
         unique case (state_ff)
            A_DIV: begin
               // restoring divide, one quotient bit a cycle
               rem_in  = unit_ge ? {1'b0, unit_diff[COUNT_W-1:0]}
                                 : {1'b0, unit_a[COUNT_W-1:0]};
               work_in = {work_ff[SQRT_W-2:0], unit_ge};
               step_in = step_ff + 1'b1;
               if (step_ff == DIV_LAST) begin
                  ratio_in = {work_ff[THRESH_W-2:0], unit_ge};
                  work_in  = {work_ff[THRESH_W-2:0], unit_ge, (SQRT_W-THRESH_W)'(0)};
                  rem_in   = '0;
                  root_in  = '0;
                  step_in  = '0;
                  state_in = A_SQRT;
               end
            end
            A_SQRT: begin
               // digit-by-digit root, two radicand bits a cycle
               rem_in  = unit_ge ? unit_diff[REM_W-1:0] : unit_a[REM_W-1:0];
               root_in = {root_ff[ROOT_W-2:0], unit_ge};
               work_in = {work_ff[SQRT_W-3:0], 2'b00};
               step_in = step_ff + 1'b1;
               if (step_ff == SQRT_LAST) begin
                  state_in = A_DONE;
               end
            end
            A_IDLE, A_DONE: begin
               state_in = state_ff;
            end
            default: state_in = A_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      work_ff  <= work_in;
      ratio_ff <= ratio_in;
      root_ff  <= root_in;
   end

   assign res.done  = (state_ff == A_DONE);
   assign res.ratio = ratio_ff;
   assign res.root  = root_ff;

endmodule

>>> sv/frequent_word_subsampler_top.sv
// channel   dir   handshake                  payload
// req       in    req_tvalid / req_tready    word_count
// rsp       out   rsp_tvalid / rsp_tready    keep, keep_probability, random_draw
// csr       in    csr_wr_en                  scaled_threshold
//
// one item at a time; the result is set by the shared subtract unit doing
// 48 divide steps then 32 square-root steps
// the generator multiply (35 shift-add steps) runs alongside the divide
// req_tready is high only while idle; a new item may be taken while a result waits
// a finished item waits for the result register to be free before it loads
// reset is synchronous; generator state returns to one, threshold to 1.0
module frequent_word_subsampler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] word_count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [0] keep, [32:1] keep_probability,
                                    // [48:33] random_draw, [55:49] zero
   input  logic        csr_wr_en,
   input  logic [47:0] csr_wr_data  // [47:0] scaled_threshold
);
   import fws_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                state_ff, state_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic                zero_ff, zero_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [55:0]         rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                load;
   logic                lcg_done;
   logic [LCG_W-1:0]    lcg_state;
   arith_res_type       arith_res;

   logic [THRESH_W:0]   sum;
   logic [PROB_W-1:0]   prob;
   logic [DRAW_W-1:0]   draw;
   logic                keep;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load       = (state_ff == ST_RUN) && arith_res.done && lcg_done
                       && (!rsp_valid_ff || rsp_tready);

   fws_lcg u_lcg (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .done  (lcg_done),
      .state (lcg_state)
   );

   fws_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .threshold (thresh_ff),
      .count     (req_tdata),
      .res       (arith_res)
   );

   assign sum  = {1'b0, arith_res.ratio} + {(THRESH_W+1-ROOT_W)'(0), arith_res.root};
   assign draw = lcg_state[DRAW_W-1:0];

   always_comb begin
      if (zero_ff || (sum[THRESH_W:PROB_W] != '0)) begin
         prob = PROB_MAX;
      end else begin
         prob = sum[PROB_W-1:0];
      end
   end

   assign keep = (prob >= {(PROB_W-DRAW_W)'(0), draw});

   always_comb begin
      state_in     = state_ff;
      thresh_in    = csr_wr_en ? csr_wr_data : thresh_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               zero_in  = (req_tdata == '0) || (thresh_ff == '0);
            end
         end
         ST_RUN: begin
            if (load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0, draw, prob, keep};
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thresh_ff    <= THRESH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thresh_ff    <= thresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // the generator multiply is shorter than divide plus root
   a_lcg_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && arith_res.done) |-> lcg_done)
      else $error("arith finished before generator");

   a_keep_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[32:1] >= {16'b0, rsp_tdata[48:33]})))
      else $error("keep flag disagrees with probability and draw");

   a_zero_sat: assert property (@(posedge clock) disable iff (reset)
      (load && zero_ff) |=> (rsp_tdata[32:1] == PROB_MAX && rsp_tdata[0]))
      else $error("zero count or threshold not saturated");

   a_accept_run: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN && !arith_res.done && !lcg_done))
      else $error("accepted item did not start the sequencers");

endmodule
